@@ rtl/t1cs_pkg.sv @@
package t1cs_pkg;

  // Key schedule constants
  localparam logic [15:0] KEY_MUL   = 16'd52845;
  localparam logic [15:0] KEY_ADD   = 16'd22719;
  localparam logic [15:0] KEY_RESET = 16'd4330;

  // Number packing constants
  localparam logic [7:0] SMALL_BIAS = 8'd139;
  localparam logic [7:0] POS_LEAD   = 8'd247;
  localparam logic [7:0] NEG_LEAD   = 8'd251;
  localparam logic [7:0] LONG_LEAD  = 8'd255;
  localparam logic signed [31:0] SMALL_MAX = 32'sd107;
  localparam logic signed [31:0] MID_MIN   = 32'sd108;
  localparam logic signed [31:0] MID_MAX   = 32'sd1131;

  // Item kinds carried in tuser (code 3 is unused)
  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_NUMBER = 2'd1,
    CMD_OPCODE = 2'd2
  } cmd_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture a packed item into the byte buffer
    logic rekey;  // reload the running key from the initial key
    logic push;   // encrypt the head byte into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a byte this cycle
    logic last_byte;  // head byte is the final one of the item
  } dp_status_t;

endpackage

@@ rtl/type1_charstring_encode_encrypt.sv @@
// Type 1 charstring encoder and encryptor. Each input beat carries one token:
// a begin item reloads the running key from the initial-key register and gives
// no output; a number is packed into one, two or five bytes; an opcode byte
// passes as is. Every byte leaves encrypted, with tlast on the final byte of
// its token. A begin item or an unused kind leaves the block idle; a number or
// opcode is accepted and its bytes are then pushed in order, paced by the key
// recurrence, which runs one byte per cycle through a single 16x16 multiplier
// while the output register is free. The input is ready again as soon as the final
// byte enters the output register, so a new token is accepted while that byte
// still waits downstream. Write the initial key only while the block is idle.
module type1_charstring_encode_encrypt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] cipher_byte
  output logic        m_axis_tlast
);

  t1cs_pkg::dp_cmd_t    dp_cmd;
  t1cs_pkg::dp_status_t dp_status;

  t1cs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .status_i      (dp_status),
    .cmd_o         (dp_cmd)
  );

  t1cs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .status_o      (dp_status),
    .item_cmd_i    (s_axis_tuser),
    .item_value_i  (s_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ rtl/t1cs_ctrl.sv @@
module t1cs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [1:0]            s_axis_tuser,
  input  t1cs_pkg::dp_status_t  status_i,
  output t1cs_pkg::dp_cmd_t     cmd_o
);

  t1cs_pkg::state_e state_q, state_d;
  logic             accept;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= t1cs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_axis_tready = (state_q == t1cs_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      t1cs_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (s_axis_tuser)
            t1cs_pkg::CMD_BEGIN: cmd_o.rekey = 1'b1;
            t1cs_pkg::CMD_NUMBER,
            t1cs_pkg::CMD_OPCODE: begin
              cmd_o.load = 1'b1;
              state_d    = t1cs_pkg::ST_EMIT;
            end
            default: ;  // unused code: drop the beat
          endcase
        end
      end
      t1cs_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.push = 1'b1;
          if (status_i.last_byte) begin
            state_d = t1cs_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = t1cs_pkg::ST_IDLE;
    endcase
  end

  // Bytes are only pushed while emitting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> state_q == t1cs_pkg::ST_EMIT)
    else $error("push outside emit state");

  // A loaded item always leads to emission
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == t1cs_pkg::ST_EMIT)
    else $error("load did not start emission");

  // Final byte pushed returns the controller to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.push && status_i.last_byte) |=> s_axis_tready)
    else $error("not idle after final byte");

endmodule

@@ rtl/t1cs_dp.sv @@
module t1cs_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  t1cs_pkg::dp_cmd_t     cmd_i,
  output t1cs_pkg::dp_status_t  status_o,
  input  logic [1:0]            item_cmd_i,
  input  logic [31:0]           item_value_i,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,
  output logic                  m_axis_tlast
);

  logic [15:0]        init_key_q;
  logic [15:0]        key_q, key_d;
  logic [4:0][7:0]    buf_q, buf_d;
  logic [2:0]         rem_q, rem_d;
  logic               out_valid_q;
  logic [7:0]         out_data_q;
  logic               out_last_q;

  logic signed [31:0] n;
  logic signed [31:0] pos_m, neg_m;
  logic               is_small, is_pos, is_neg;
  logic [7:0]         cipher;
  logic [15:0]        key_sum;
  logic [31:0]        key_prod;

  // Initial key register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_key_q <= t1cs_pkg::KEY_RESET;
    end else if (cfg_we_i) begin
      init_key_q <= cfg_wdata_i;
    end
  end

  // Classify the number and form the two-byte offsets
  assign n        = $signed(item_value_i);
  assign is_small = (n >= -t1cs_pkg::SMALL_MAX) && (n <= t1cs_pkg::SMALL_MAX);
  assign is_pos   = (n >= t1cs_pkg::MID_MIN) && (n <= t1cs_pkg::MID_MAX);
  assign is_neg   = (n >= -t1cs_pkg::MID_MAX) && (n <= -t1cs_pkg::MID_MIN);
  assign pos_m    = n - t1cs_pkg::MID_MIN;
  assign neg_m    = -n - t1cs_pkg::MID_MIN;

  // Pack on load, shift one byte out on push
  always_comb begin
    buf_d = buf_q;
    rem_d = rem_q;
    if (cmd_i.load) begin
      buf_d = '0;
      if (item_cmd_i == t1cs_pkg::CMD_OPCODE) begin
        buf_d[0] = item_value_i[7:0];
        rem_d    = 3'd0;
      end else if (is_small) begin
        buf_d[0] = item_value_i[7:0] + t1cs_pkg::SMALL_BIAS;
        rem_d    = 3'd0;
      end else if (is_pos) begin
        buf_d[0] = t1cs_pkg::POS_LEAD + {6'd0, pos_m[9:8]};
        buf_d[1] = pos_m[7:0];
        rem_d    = 3'd1;
      end else if (is_neg) begin
        buf_d[0] = t1cs_pkg::NEG_LEAD + {6'd0, neg_m[9:8]};
        buf_d[1] = neg_m[7:0];
        rem_d    = 3'd1;
      end else begin
        buf_d[0] = t1cs_pkg::LONG_LEAD;
        buf_d[1] = item_value_i[31:24];
        buf_d[2] = item_value_i[23:16];
        buf_d[3] = item_value_i[15:8];
        buf_d[4] = item_value_i[7:0];
        rem_d    = 3'd4;
      end
    end else if (cmd_i.push) begin
      buf_d = {8'd0, buf_q[4:1]};
      rem_d = rem_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    rem_q <= rem_d;
  end

  // Encrypt the head byte and advance the key
  assign cipher   = buf_q[0] ^ key_q[15:8];
  assign key_sum  = {8'd0, cipher} + key_q;
  assign key_prod = 32'(key_sum) * 32'(t1cs_pkg::KEY_MUL);

  always_comb begin
    key_d = key_q;
    if (cmd_i.rekey) begin
      key_d = init_key_q;
    end else if (cmd_i.push) begin
      key_d = key_prod[15:0] + t1cs_pkg::KEY_ADD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= t1cs_pkg::KEY_RESET;
    end else begin
      key_q <= key_d;
    end
  end

  // Output register: hold until the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_data_q <= cipher;
      out_last_q <= (rem_q == 3'd0);
    end
  end

  assign m_axis_tvalid      = out_valid_q;
  assign m_axis_tdata       = out_data_q;
  assign m_axis_tlast       = out_last_q;
  assign status_o.out_free  = !out_valid_q || m_axis_tready;
  assign status_o.last_byte = (rem_q == 3'd0);

  // Never overwrite a beat that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (!out_valid_q || m_axis_tready))
    else $error("output beat overwritten");

  // A begin item loads the configured key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rekey |=> key_q == $past(init_key_q))
    else $error("key not reloaded");

  // Loaded items hold at most five bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> rem_q <= 3'd4)
    else $error("byte count out of range");

endmodule

@@ sim/charstring_cipher_checker.sv @@
module charstring_cipher_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [7:0] cipher_byte
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [7:0] cipher;
    logic       is_last;
  } cipher_beat_t;

  logic [15:0]  initial_key;
  logic [15:0]  running_key;
  cipher_beat_t expected_cipher_q[$];

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    fail_count_o++;
  endtask

  // Encrypt one plain byte, advance the key, queue the cipher beat
  task automatic encrypt_plain(input logic [7:0] plain, input logic is_last);
    cipher_beat_t beat;
    logic [31:0]  next_key;
    beat.cipher  = plain ^ running_key[15:8];
    beat.is_last = is_last;
    next_key = (32'(beat.cipher) + 32'(running_key)) * 32'(t1cs_pkg::KEY_MUL)
               + 32'(t1cs_pkg::KEY_ADD);
    running_key = next_key[15:0];
    expected_cipher_q.push_back(beat);
  endtask

  // Pack one token into plain bytes and encrypt them in order
  task automatic predict_token(input logic [1:0] cmd, input logic [31:0] value);
    logic [7:0]         plain [0:4];
    logic signed [31:0] n;
    logic [31:0]        m;
    int                 count;
    n = value;
    count = 0;
    case (cmd)
      t1cs_pkg::CMD_BEGIN: begin
        running_key = initial_key;
      end
      t1cs_pkg::CMD_NUMBER: begin
        if (n >= -t1cs_pkg::SMALL_MAX && n <= t1cs_pkg::SMALL_MAX) begin
          plain[0] = n[7:0] + t1cs_pkg::SMALL_BIAS;
          count = 1;
        end else if (n >= t1cs_pkg::MID_MIN && n <= t1cs_pkg::MID_MAX) begin
          m = n - t1cs_pkg::MID_MIN;
          plain[0] = t1cs_pkg::POS_LEAD + {6'd0, m[9:8]};
          plain[1] = m[7:0];
          count = 2;
        end else if (n >= -t1cs_pkg::MID_MAX && n <= -t1cs_pkg::MID_MIN) begin
          m = -n - t1cs_pkg::MID_MIN;
          plain[0] = t1cs_pkg::NEG_LEAD + {6'd0, m[9:8]};
          plain[1] = m[7:0];
          count = 2;
        end else begin
          plain[0] = t1cs_pkg::LONG_LEAD;
          plain[1] = value[31:24];
          plain[2] = value[23:16];
          plain[3] = value[15:8];
          plain[4] = value[7:0];
          count = 5;
        end
      end
      t1cs_pkg::CMD_OPCODE: begin
        plain[0] = value[7:0];
        count = 1;
      end
      default: ;  // unused kind: no bytes, key untouched
    endcase
    for (int k = 0; k < count; k++) encrypt_plain(plain[k], k == count - 1);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cipher_beat_t want;
    if (!rst_ni) begin
      initial_key = t1cs_pkg::KEY_RESET;
      running_key = t1cs_pkg::KEY_RESET;
      expected_cipher_q.delete();
    end else begin
      // Track the key register
      if (cfg_we_i) initial_key = cfg_wdata_i;
      // Predict the bytes of an accepted token
      if (s_axis_tvalid && s_axis_tready) predict_token(s_axis_tuser, s_axis_tdata);
      // Compare each output beat with the oldest expected byte
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_cipher_q.size() == 0) begin
          report_mismatch($sformatf("unexpected cipher beat 0x%02h last %0b",
                                    m_axis_tdata, m_axis_tlast));
        end else begin
          want = expected_cipher_q.pop_front();
          if (m_axis_tdata !== want.cipher)
            report_mismatch($sformatf("cipher byte 0x%02h, expected 0x%02h",
                                      m_axis_tdata, want.cipher));
          if (m_axis_tlast !== want.is_last)
            report_mismatch($sformatf("tlast %0b, expected %0b on byte 0x%02h",
                                      m_axis_tlast, want.is_last, want.cipher));
        end
      end
    end
    pending_o = expected_cipher_q.size();
  end

endmodule

@@ sim/tb_type1_charstring_encode_encrypt.sv @@
module tb_type1_charstring_encode_encrypt;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RX_ALWAYS    = 0;
  localparam int RX_COIN      = 1;
  localparam int RX_SPARSE    = 2;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 100;
  localparam int NUM_PHASES   = 5;
  localparam int DRAIN_CYCLES = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  int fail_count;
  int pending_beats;
  int rx_mode       = RX_ALWAYS;
  int hold_requests = 0;
  int holds_served  = 0;
  int burst_left    = 0;
  int gap_max       = 0;
  int items_sent    = 0;

  type1_charstring_encode_encrypt uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  charstring_cipher_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending_beats)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Bound the run
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Drive tready: serve long hold requests, otherwise follow the current mode
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests > holds_served) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        holds_served++;
      end
      case (rx_mode)
        RX_COIN:   m_axis_tready = $urandom_range(0, 1) == 1;
        RX_SPARSE: m_axis_tready = $urandom_range(0, 3) == 0;
        default:   m_axis_tready = 1'b1;
      endcase
    end
  end

  // Offer one beat in bursts with random gaps; return at the negedge after acceptance
  task automatic send_item(input logic [1:0] cmd, input logic [31:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = value;
    s_axis_tuser  = cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    burst_left--;
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  // Pick a number biased toward the packing classes and their borders
  function automatic logic [31:0] random_number();
    logic [31:0] mag;
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 214)) - 32'd107;
      1: return 32'($urandom_range(108, 1131));
      2: return -32'($urandom_range(108, 1131));
      3: begin
        mag = 32'($urandom_range(1132, 70000));
        return ($urandom_range(0, 1) == 1) ? -mag : mag;
      end
      4: begin
        case ($urandom_range(0, 3))
          0:       mag = 32'd107;
          1:       mag = 32'd108;
          2:       mag = 32'd1131;
          default: mag = 32'd1132;
        endcase
        return ($urandom_range(0, 1) == 1) ? -mag : mag;
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_token();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5)       send_item(CMD_UNUSED, $urandom);
    else if (pick < 35) send_item(t1cs_pkg::CMD_OPCODE, $urandom);
    else                send_item(t1cs_pkg::CMD_NUMBER, random_number());
  endtask

  task automatic send_charstring();
    int len;
    len = $urandom_range(1, 12);
    send_item(t1cs_pkg::CMD_BEGIN, $urandom);
    repeat (len) send_random_token();
  endtask

  // Drop valid and let every expected byte come out before touching the key
  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (pending_beats != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int          phase_end;
    logic [15:0] key;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = t1cs_pkg::CMD_BEGIN;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: bytes before any begin use the reset key, then class borders
    send_item(t1cs_pkg::CMD_OPCODE, 32'h0000_0000);
    send_item(t1cs_pkg::CMD_OPCODE, 32'hABCD_EFFF);
    send_item(t1cs_pkg::CMD_NUMBER, 32'd0);
    send_item(t1cs_pkg::CMD_NUMBER, -32'd107);
    send_item(t1cs_pkg::CMD_NUMBER, 32'd107);
    send_item(t1cs_pkg::CMD_NUMBER, 32'd108);
    send_item(t1cs_pkg::CMD_NUMBER, 32'd1131);
    send_item(t1cs_pkg::CMD_NUMBER, -32'd108);
    send_item(t1cs_pkg::CMD_NUMBER, -32'd1131);
    send_item(t1cs_pkg::CMD_NUMBER, 32'd1132);
    send_item(t1cs_pkg::CMD_NUMBER, -32'd1132);
    send_item(CMD_UNUSED,           32'hFFFF_FFFF);
    send_item(t1cs_pkg::CMD_BEGIN,  32'h0000_0000);
    send_item(t1cs_pkg::CMD_NUMBER, 32'h7FFF_FFFF);
    send_item(t1cs_pkg::CMD_NUMBER, 32'h8000_0000);
    send_item(t1cs_pkg::CMD_NUMBER, 32'hFFFF_FFFF);
    send_item(CMD_UNUSED,           32'h0000_0000);
    send_item(t1cs_pkg::CMD_OPCODE, 32'h0000_000E);
    send_item(t1cs_pkg::CMD_BEGIN,  32'hFFFF_FFFF);
    send_item(t1cs_pkg::CMD_OPCODE, 32'h0000_000D);

    // Random phases, each under its own key and flow-control mix
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      case (p)
        0:       key = 16'h0000;
        1:       key = 16'hFFFF;
        4:       key = t1cs_pkg::KEY_RESET;
        default: key = 16'($urandom);
      endcase
      cfg_we_i    = 1'b1;
      cfg_wdata_i = key;
      @(negedge clk_i);
      cfg_we_i = 1'b0;
      rx_mode  = p % 3;
      case (p)
        0:       gap_max = 3;
        2:       gap_max = 6;
        4:       gap_max = 2;
        default: gap_max = 0;
      endcase
      if (p == 3) hold_requests++;
      phase_end = items_sent + PHASE_ITEMS;
      // Tokens before the first begin still run on the previous key
      send_item(t1cs_pkg::CMD_OPCODE, $urandom);
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 9) < 8) send_charstring();
        else send_random_token();
      end
    end
    wait_idle();

    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/t1cs_pkg.sv
rtl/t1cs_ctrl.sv
rtl/t1cs_dp.sv
rtl/type1_charstring_encode_encrypt.sv
sim/charstring_cipher_checker.sv
sim/tb_type1_charstring_encode_encrypt.sv
